// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define ASSERT_SAME(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// ===== rtl/core/lpdm_pkg.sv =====
// constants and types of the longest prefix dictionary match block
// no dependencies
package lpdm_pkg;
   localparam int MAX_ENTRIES = 512;
   localparam int WORD_LEN    = 20;

   localparam int IDX_W       = 9;
   localparam int POS_W       = 5;
   localparam int CHAR_W      = 7;
   localparam int ENTRY_W     = $clog2(MAX_ENTRIES);
   localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
   localparam int LEN_W       = $clog2(WORD_LEN + 1);
   localparam int QIDX_W      = $clog2(WORD_LEN);
   localparam int CHAR_ADDR_W = $clog2(MAX_ENTRIES * WORD_LEN);

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QLEN,
      ST_LEN,
      ST_LENW,
      ST_CHR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic qlen_load;
      logic scan_start;
      logic len_read;
      logic char_first;
      logic char_next;
      logic entry_next;
      logic take_best;
      logic result_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic query_end;
      logic scan_done;
      logic len_zero;
      logic chr_end;
      logic rsp_free;
   } dp_stat_type;
endpackage

// ===== rtl/core/lpdm_if.sv =====
// request and response channel interfaces
// depends on lpdm_pkg
interface lpdm_req_if;
   import lpdm_pkg::*;
   logic              valid;
   logic              ready;
   logic              command;
   logic [IDX_W-1:0]  entry_index;
   logic [POS_W-1:0]  char_pos;
   logic [CHAR_W-1:0] char_value;
   logic              last;

   modport source (output valid, command, entry_index, char_pos, char_value, last,
                   input ready);
   modport sink (input valid, command, entry_index, char_pos, char_value, last,
                 output ready);
endinterface

interface lpdm_rsp_if;
   import lpdm_pkg::*;
   logic             valid;
   logic             ready;
   logic             found;
   logic [IDX_W-1:0] code;

   modport source (output valid, found, code, input ready);
   modport sink (input valid, found, code, output ready);
endinterface

// ===== rtl/core/longest_prefix_dictionary_match.sv =====
// Longest prefix dictionary match. Load beats write one word character each and are accepted
// in the idle state, as are query beats that are not the last. On the last query beat the
// block scans entries 0 to entry_count-1 of the word memory, one stored character per cycle
// and stopping at the first mismatch or at the end of the stored word, and takes no new beats
// until the result is loaded; the single read port of the word memory sets that pace.
// The result sits in an output register while new beats are taken. Stores are not cleared.
// depends on lpdm_pkg, lpdm_if, lpdm_ram, lpdm_ctrl and lpdm_dp
module longest_prefix_dictionary_match (
   input logic         clock,
   input logic         reset,
   lpdm_req_if.sink    req_ch,
   lpdm_rsp_if.source  rsp_ch
);
   import lpdm_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // controller
   lpdm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   lpdm_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_ch.command),
      .req_entry_index (req_ch.entry_index),
      .req_char_pos    (req_ch.char_pos),
      .req_char_value  (req_ch.char_value),
      .req_last        (req_ch.last),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_found       (rsp_ch.found),
      .rsp_code        (rsp_ch.code),
      .cmd             (cmd),
      .stat            (stat)
   );
endmodule

// ===== rtl/core/lpdm_ram.sv =====
// generic simple dual port ram with registered read
// no dependencies
module lpdm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/lpdm_ctrl.sv =====
// controller state machine for the dictionary scan
// depends on lpdm_pkg and assert_macros.svh
`include "assert_macros.svh"
module lpdm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lpdm_pkg::dp_stat_type stat,
   output lpdm_pkg::ctrl_cmd_type cmd
);
   import lpdm_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && stat.query_end) begin
               state_in = ST_QLEN;
            end
         end
         ST_QLEN: begin
            cmd.qlen_load  = 1'b1;
            cmd.scan_start = 1'b1;
            state_in       = ST_LEN;
         end
         ST_LEN: begin
            if (stat.scan_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.len_read = 1'b1;
               state_in     = ST_LENW;
            end
         end
         ST_LENW: begin
            if (stat.len_zero) begin
               cmd.entry_next = 1'b1;
               state_in       = ST_LEN;
            end else begin
               cmd.char_first = 1'b1;
               state_in       = ST_CHR;
            end
         end
         ST_CHR: begin
            if (stat.chr_end) begin
               cmd.take_best  = 1'b1;
               cmd.entry_next = 1'b1;
               state_in       = ST_LEN;
            end else begin
               cmd.char_next = 1'b1;
            end
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `ASSERT_NEXT(a_query_starts, clock, reset, state_ff == ST_IDLE && req_valid && stat.query_end, state_ff == ST_QLEN, "query end did not start a scan")
   `ASSERT_NEXT(a_done_returns, clock, reset, state_ff == ST_DONE && stat.rsp_free, state_ff == ST_IDLE, "result load did not return to idle")
endmodule

// ===== rtl/core/lpdm_dp.sv =====
// datapath: word stores, query buffer, scan counters, result register
// depends on lpdm_pkg, lpdm_ram and assert_macros.svh
`include "assert_macros.svh"
module lpdm_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_command,
   input  logic [lpdm_pkg::IDX_W-1:0]     req_entry_index,
   input  logic [lpdm_pkg::POS_W-1:0]     req_char_pos,
   input  logic [lpdm_pkg::CHAR_W-1:0]    req_char_value,
   input  logic                           req_last,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic                           rsp_found,
   output logic [lpdm_pkg::IDX_W-1:0]     rsp_code,
   input  lpdm_pkg::ctrl_cmd_type         cmd,
   output lpdm_pkg::dp_stat_type          stat
);
   import lpdm_pkg::*;

   logic [COUNT_W-1:0]     count_ff;
   logic [CHAR_W-1:0]      query_ff [WORD_LEN];
   logic [LEN_W-1:0]       qraw_ff;
   logic [LEN_W-1:0]       qlen_ff;
   logic [COUNT_W-1:0]     e_ff;
   logic [CHAR_ADDR_W-1:0] base_ff;
   logic [LEN_W-1:0]       k_ff;
   logic [LEN_W-1:0]       n_ff;
   logic [IDX_W-1:0]       best_ff;
   logic [LEN_W-1:0]       best_len_ff;
   logic                   rsp_valid_ff;
   logic                   found_ff;
   logic [IDX_W-1:0]       code_ff;

   logic                   is_load, load_ok, pos_ok;
   logic [LEN_W-1:0]       pos_len;
   logic [LEN_W-1:0]       qlen_in;
   logic [LEN_W-1:0]       kp1;
   logic [CHAR_W-1:0]      chr;
   logic [LEN_W-1:0]       len_rd;
   logic                   chr_zero, chr_fail, chr_full, chr_hit;
   logic [LEN_W-1:0]       cand_len;
   logic [CHAR_ADDR_W-1:0] wr_char_addr, rd_char_addr;

   // load decode
   assign is_load = cmd.accept && (req_command == CMD_LOAD);
   assign load_ok = is_load && (COUNT_W'(req_entry_index) < COUNT_W'(MAX_ENTRIES));
   assign pos_ok  = LEN_W'(req_char_pos) < LEN_W'(WORD_LEN);
   assign pos_len = pos_ok ? LEN_W'(req_char_pos) + LEN_W'(1) : LEN_W'(WORD_LEN);
   assign wr_char_addr = CHAR_ADDR_W'(req_entry_index) * CHAR_ADDR_W'(WORD_LEN)
                       + CHAR_ADDR_W'(req_char_pos);

   // character scan address
   assign kp1 = k_ff + LEN_W'(1);
   assign rd_char_addr = cmd.char_first ? base_ff : base_ff + CHAR_ADDR_W'(kp1);

   lpdm_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_ENTRIES * WORD_LEN)) u_chars (
      .clock   (clock),
      .wr_en   (load_ok && pos_ok),
      .wr_addr (wr_char_addr),
      .wr_data (req_char_value),
      .rd_en   (cmd.char_first || cmd.char_next),
      .rd_addr (rd_char_addr),
      .rd_data (chr)
   );

   lpdm_ram #(.WIDTH(LEN_W), .DEPTH(MAX_ENTRIES)) u_lens (
      .clock   (clock),
      .wr_en   (load_ok && req_last),
      .wr_addr (ENTRY_W'(req_entry_index)),
      .wr_data (pos_len),
      .rd_en   (cmd.len_read),
      .rd_addr (e_ff[ENTRY_W-1:0]),
      .rd_data (len_rd)
   );

   // query length stops at the first zero character
   always_comb begin
      qlen_in = qraw_ff;
      for (int i = WORD_LEN - 1; i >= 0; i--) begin
         if (LEN_W'(i) < qraw_ff && query_ff[i] == '0) begin
            qlen_in = LEN_W'(i);
         end
      end
   end

   // compare of one stored character against the query
   always_comb begin
      chr_zero = (chr == '0);
      chr_fail = !chr_zero && ((k_ff >= qlen_ff) || (chr != query_ff[k_ff[QIDX_W-1:0]]));
      chr_full = !chr_zero && !chr_fail && (kp1 == n_ff);
      chr_hit  = (chr_zero && (k_ff != '0) && (k_ff <= qlen_ff)) || chr_full;
      cand_len = chr_zero ? k_ff : kp1;
   end

   assign stat.query_end = (req_command == CMD_QUERY) && req_last;
   assign stat.scan_done = (e_ff >= count_ff);
   assign stat.len_zero  = (len_rd == '0);
   assign stat.chr_end   = chr_zero || chr_fail || chr_full;
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_ok && req_last &&
             (COUNT_W'(req_entry_index) + COUNT_W'(1) > count_ff)) begin
            count_ff <= COUNT_W'(req_entry_index) + COUNT_W'(1);
         end
         if (cmd.result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // query buffer and scan datapath
   always_ff @(posedge clock) begin
      if (cmd.accept && req_command == CMD_QUERY) begin
         if (pos_ok) begin
            query_ff[req_char_pos[QIDX_W-1:0]] <= req_char_value;
         end
         qraw_ff <= pos_len;
      end
      if (cmd.qlen_load) begin
         qlen_ff <= qlen_in;
      end
      if (cmd.scan_start) begin
         e_ff        <= '0;
         base_ff     <= '0;
         best_ff     <= '0;
         best_len_ff <= '0;
      end
      if (cmd.char_first) begin
         n_ff <= len_rd;
         k_ff <= '0;
      end
      if (cmd.char_next) begin
         k_ff <= kp1;
      end
      if (cmd.take_best && chr_hit && cand_len > best_len_ff) begin
         best_ff     <= e_ff[IDX_W-1:0];
         best_len_ff <= cand_len;
      end
      if (cmd.entry_next) begin
         e_ff    <= e_ff + COUNT_W'(1);
         base_ff <= base_ff + CHAR_ADDR_W'(WORD_LEN);
      end
      if (cmd.result_load) begin
         found_ff <= (best_len_ff != '0);
         code_ff  <= best_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = found_ff;
   assign rsp_code  = code_ff;

   `ASSERT_SAME(a_best_in_query, clock, reset, cmd.result_load, best_len_ff <= qlen_ff, "matched length exceeds query length")
endmodule
